/* sv/gctt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and tables of the great-circle travel-time block.
package gctt_pkg;

	localparam int LAT_W      = 24;
	localparam int LON_W      = 25;
	localparam int LEG_W      = 23;
	localparam int TIME_W     = 32;
	localparam int SPEED_W    = 24;
	localparam int LAY_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int SUM_W      = 32;

	localparam int MAX_STOPS    = 256;
	localparam int CORDIC_STEPS = 24;
	localparam int CNT_W        = $clog2(MAX_STOPS + 1);

	localparam int STEP_W     = 6;
	localparam int SQRT_STEPS = 32;
	localparam int DVD_W      = SUM_W + 8;
	localparam int DIV_STEPS  = DVD_W;

	localparam int DEG_W  = 26;
	localparam int MAG_W  = 23;
	localparam int ANG_W  = 34;
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic signed [DEG_W-1:0] Q16_90  = 26'sd5898240;
	localparam logic signed [DEG_W-1:0] Q16_180 = 26'sd11796480;
	localparam logic signed [DEG_W-1:0] Q16_360 = 26'sd23592960;

	localparam logic [26:0] DEG2RAD_K = 27'd74961321;

	localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] ONE_Q30     = 34'sd1073741824;

	localparam logic [12:0]      EARTH_KM = 13'd6371;
	localparam logic [LEG_W-1:0] LEG_MAX  = 23'd5124096;

	localparam logic [SPEED_W-1:0] SPEED_RESET   = 24'd256000;
	localparam logic [LAY_W-1:0]   LAYOVER_RESET = 16'd256;

	localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYOVER = 2'd1;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_RAD, S_RLOAD, S_ROT, S_RSTORE,
		S_MSS, S_MCC, S_MCCD, S_ARG, S_MSQ, S_SLOAD, S_SQRT,
		S_VLOAD, S_VEC, S_MKM, S_LEG, S_ACCUM, S_DLOAD, S_DIV,
		S_TIME, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		MUL_RAD, MUL_SS, MUL_CC, MUL_CCD, MUL_SQ, MUL_KM
	} mul_sel_t;

	// which angle the sin/cos pass works on
	typedef enum logic [1:0] {
		SLOT_A, SLOT_B, SLOT_D
	} slot_t;

	typedef struct packed {
		logic              take_in;
		logic              mul_en;
		mul_sel_t          mul;
		slot_t             slot;
		logic [STEP_W-1:0] step;
		logic              rot_load;
		logic              rot_step;
		logic              store_sc;
		logic              p1_save;
		logic              arg_load;
		logic              sqrt_load;
		logic              sqrt_step;
		logic              vec_load;
		logic              vec_step;
		logic              leg_load;
		logic              leg_zero;
		logic              accum;
		logic              div_load;
		logic              div_step;
		logic              time_load;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic leg_ok;
		logic last;
		logic out_free;
	} status_t;

	// arctangent of 2^-i, radians Q30, truncated
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'd843314856;
			5'd1:  v = 32'd497837829;
			5'd2:  v = 32'd263043836;
			5'd3:  v = 32'd133525158;
			5'd4:  v = 32'd67021686;
			5'd5:  v = 32'd33543515;
			5'd6:  v = 32'd16775850;
			5'd7:  v = 32'd8388437;
			5'd8:  v = 32'd4194282;
			5'd9:  v = 32'd2097149;
			5'd10: v = 32'd1048575;
			5'd11: v = 32'd524287;
			5'd12: v = 32'd262143;
			5'd13: v = 32'd131071;
			5'd14: v = 32'd65535;
			5'd15: v = 32'd32767;
			5'd16: v = 32'd16383;
			5'd17: v = 32'd8191;
			5'd18: v = 32'd4095;
			5'd19: v = 32'd2047;
			5'd20: v = 32'd1023;
			5'd21: v = 32'd511;
			5'd22: v = 32'd255;
			5'd23: v = 32'd127;
			5'd24: v = 32'd63;
			5'd25: v = 32'd31;
			5'd26: v = 32'd15;
			5'd27: v = 32'd8;
			5'd28: v = 32'd4;
			5'd29: v = 32'd2;
			5'd30: v = 32'd1;
			5'd31: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

/* sv/gctt_if.sv */
`timescale 1ns / 1ps
// Channel interfaces: stop items in, result items out, configuration writes.
interface gctt_stop_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [gctt_pkg::LAT_W-1:0]    latitude;
	logic signed [gctt_pkg::LON_W-1:0]    longitude;
	logic                                 last_stop;
	modport source(output valid, output latitude, output longitude, output last_stop,
		input ready);
	modport sink(input valid, input latitude, input longitude, input last_stop,
		output ready);
endinterface

interface gctt_result_if;
	logic                           valid;
	logic                           ready;
	logic [gctt_pkg::LEG_W-1:0]     leg_distance;
	logic [gctt_pkg::TIME_W-1:0]    total_time;
	logic                           route_done;
	logic                           speed_error;
	modport source(output valid, output leg_distance, output total_time,
		output route_done, output speed_error, input ready);
	modport sink(input valid, input leg_distance, input total_time,
		input route_done, input speed_error, output ready);
endinterface

interface gctt_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [gctt_pkg::CFG_IDX_W-1:0]    index;
	logic [gctt_pkg::CFG_DATA_W-1:0]   data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* sv/gctt_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer that steps the datapath through one stop item.
module gctt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gctt_pkg::status_t st,
	output gctt_pkg::cmd_t    cmd
);
	import gctt_pkg::*;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	slot_t             slot_q, slot_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			slot_q  <= SLOT_A;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			slot_q  <= slot_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		slot_d   = slot_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.slot = slot_q;
		cmd.step = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.leg_ok) begin
					slot_d  = SLOT_A;
					state_d = S_RAD;
				end else begin
					cmd.leg_zero = 1'b1;
					state_d      = S_ACCUM;
				end
			end
			S_RAD: begin
				cmd.mul_en = 1'b1;
				cmd.mul    = MUL_RAD;
				state_d    = S_RLOAD;
			end
			S_RLOAD: begin
				cmd.rot_load = 1'b1;
				cnt_d        = '0;
				state_d      = S_ROT;
			end
			S_ROT: begin
				cmd.rot_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(CORDIC_STEPS - 1))
					state_d = S_RSTORE;
			end
			S_RSTORE: begin
				cmd.store_sc = 1'b1;
				if (slot_q == SLOT_D) begin
					state_d = S_MSS;
				end else begin
					slot_d  = (slot_q == SLOT_A) ? SLOT_B : SLOT_D;
					state_d = S_RAD;
				end
			end
			S_MSS: begin
				cmd.mul_en = 1'b1;
				cmd.mul    = MUL_SS;
				state_d    = S_MCC;
			end
			S_MCC: begin
				cmd.p1_save = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul     = MUL_CC;
				state_d     = S_MCCD;
			end
			S_MCCD: begin
				cmd.mul_en = 1'b1;
				cmd.mul    = MUL_CCD;
				state_d    = S_ARG;
			end
			S_ARG: begin
				cmd.arg_load = 1'b1;
				state_d      = S_MSQ;
			end
			S_MSQ: begin
				cmd.mul_en = 1'b1;
				cmd.mul    = MUL_SQ;
				state_d    = S_SLOAD;
			end
			S_SLOAD: begin
				cmd.sqrt_load = 1'b1;
				cnt_d         = '0;
				state_d       = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(SQRT_STEPS - 1))
					state_d = S_VLOAD;
			end
			S_VLOAD: begin
				cmd.vec_load = 1'b1;
				cnt_d        = '0;
				state_d      = S_VEC;
			end
			S_VEC: begin
				cmd.vec_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(CORDIC_STEPS - 1))
					state_d = S_MKM;
			end
			S_MKM: begin
				cmd.mul_en = 1'b1;
				cmd.mul    = MUL_KM;
				state_d    = S_LEG;
			end
			S_LEG: begin
				cmd.leg_load = 1'b1;
				state_d      = S_ACCUM;
			end
			S_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = st.last ? S_DLOAD : S_DONE;
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1))
					state_d = S_TIME;
			end
			S_TIME: begin
				cmd.time_load = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CHECK))
		else $error("accepted item did not start processing");

	a_cordic_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT || state_q == S_VEC) |-> (cnt_q < STEP_W'(CORDIC_STEPS)))
		else $error("cordic step count overran");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result loaded over an untaken result");

endmodule

/* sv/gctt_dp.sv */
`timescale 1ns / 1ps
// Datapath: route state, shared multiplier, CORDIC, square root and divider.
module gctt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gctt_pkg::cmd_t                      cmd,
	output gctt_pkg::status_t                   st,
	input  logic signed [gctt_pkg::LAT_W-1:0]   latitude,
	input  logic signed [gctt_pkg::LON_W-1:0]   longitude,
	input  logic                                last_stop,
	input  logic                                cfg_valid,
	input  logic [gctt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gctt_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [gctt_pkg::LEG_W-1:0]          leg_distance,
	output logic [gctt_pkg::TIME_W-1:0]         total_time,
	output logic                                route_done,
	output logic                                speed_error
);
	import gctt_pkg::*;

	// configuration
	logic [SPEED_W-1:0] speed_q;
	logic [LAY_W-1:0]   layover_q;

	// route state
	logic signed [LAT_W-1:0] prev_lat_q, cur_lat_q;
	logic signed [LON_W-1:0] prev_lon_q, cur_lon_q;
	logic                    have_prev_q, last_q;
	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        cnt_q;

	// arithmetic
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_d, prod_q, prod_sh;
	logic [PROD_W-1:0]        prod_u;
	logic signed [ANG_W-1:0]  x_q, y_q, z_q;
	logic signed [MUL_W-1:0]  sa_q, ca_q, sb_q, cb_q, cd_q, p1_q, arg_q;
	logic                     neg_q, sgn_q;
	logic [63:0]              rad_q;
	logic [33:0]              rem_q;
	logic [31:0]              root_q;
	logic [DVD_W-1:0]         dvd_q;
	logic [SPEED_W-1:0]       drem_q;
	logic [LEG_W-1:0]         leg_q;
	logic [TIME_W-1:0]        time_q;
	logic                     err_q;

	// output register
	logic                     out_valid_q;
	logic [LEG_W-1:0]         out_leg_q;
	logic [TIME_W-1:0]        out_time_q;
	logic                     out_done_q, out_err_q;

	// ---------------- angle selection and folding ----------------
	logic signed [DEG_W-1:0] dlon_raw, dlon, deg_sel, deg_f, deg_abs;
	logic                    fold_neg;
	logic [MAG_W-1:0]        rad_mag;

	always_comb begin
		dlon_raw = DEG_W'(cur_lon_q) - DEG_W'(prev_lon_q);
		if (dlon_raw > Q16_180)
			dlon = dlon_raw - Q16_360;
		else if (dlon_raw < -Q16_180)
			dlon = dlon_raw + Q16_360;
		else
			dlon = dlon_raw;
		unique case (cmd.slot)
			SLOT_A:  deg_sel = DEG_W'(prev_lat_q);
			SLOT_B:  deg_sel = DEG_W'(cur_lat_q);
			SLOT_D:  deg_sel = dlon;
			default: deg_sel = dlon;
		endcase
		// fold into [-90, 90]; cosine changes sign
		fold_neg = 1'b1;
		if (deg_sel > Q16_90)
			deg_f = Q16_180 - deg_sel;
		else if (deg_sel < -Q16_90)
			deg_f = -Q16_180 - deg_sel;
		else begin
			deg_f    = deg_sel;
			fold_neg = 1'b0;
		end
		deg_abs = deg_f[DEG_W-1] ? -deg_f : deg_f;
		rad_mag = deg_abs[MAG_W-1:0];
	end

	// ---------------- range check ----------------
	logic prev_ok, cur_ok;
	always_comb begin
		prev_ok = (DEG_W'(prev_lat_q) <= Q16_90) && (DEG_W'(prev_lat_q) >= -Q16_90) &&
			(DEG_W'(prev_lon_q) <= Q16_180) && (DEG_W'(prev_lon_q) >= -Q16_180);
		cur_ok = (DEG_W'(cur_lat_q) <= Q16_90) && (DEG_W'(cur_lat_q) >= -Q16_90) &&
			(DEG_W'(cur_lon_q) <= Q16_180) && (DEG_W'(cur_lon_q) >= -Q16_180);
	end

	// ---------------- shared multiplier ----------------
	logic signed [ANG_W-1:0] ang_c;
	always_comb begin
		if (z_q < 0)
			ang_c = '0;
		else if (z_q > PI_Q30)
			ang_c = PI_Q30;
		else
			ang_c = z_q;
	end

	assign prod_sh = prod_q >>> 30;
	assign prod_u  = prod_q;

	always_comb begin
		unique case (cmd.mul)
			MUL_RAD: begin
				mul_a = MUL_W'({1'b0, rad_mag});
				mul_b = MUL_W'({1'b0, DEG2RAD_K});
			end
			MUL_SS: begin
				mul_a = sa_q;
				mul_b = sb_q;
			end
			MUL_CC: begin
				mul_a = ca_q;
				mul_b = cb_q;
			end
			MUL_CCD: begin
				mul_a = prod_sh[MUL_W-1:0];
				mul_b = cd_q;
			end
			MUL_SQ: begin
				mul_a = arg_q;
				mul_b = arg_q;
			end
			MUL_KM: begin
				mul_a = ang_c[MUL_W-1:0];
				mul_b = MUL_W'({1'b0, EARTH_KM});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_d = mul_a * mul_b;
	end

	// ---------------- CORDIC step ----------------
	logic [4:0]              sh;
	logic signed [ANG_W-1:0] dx, dy, at, z0, x_neg;
	logic [PROD_W-1:0]       rad_sum, km_sum;
	logic [30:0]             rad_r;
	logic signed [ANG_W-1:0] arg_sum, root_s;

	always_comb begin
		sh      = cmd.step[4:0];
		dx      = y_q >>> sh;
		dy      = x_q >>> sh;
		at      = ANG_W'({1'b0, atan_q30(sh)});
		rad_sum = prod_u + PROD_W'(131072);
		rad_r   = rad_sum[48:18];
		z0      = sgn_q ? -ANG_W'({1'b0, rad_r}) : ANG_W'({1'b0, rad_r});
		x_neg   = neg_q ? -x_q : x_q;
		arg_sum = ANG_W'(p1_q) + ANG_W'($signed(prod_sh[MUL_W-1:0]));
		root_s  = ANG_W'({1'b0, root_q});
		km_sum  = prod_u + PROD_W'(2097152);
	end

	// ---------------- square root step ----------------
	logic [33:0] sq_r2, sq_trial;
	logic        sq_ge;
	always_comb begin
		sq_r2    = {rem_q[31:0], rad_q[63:62]};
		sq_trial = {root_q, 2'b01};
		sq_ge    = sq_r2 >= sq_trial;
	end

	// ---------------- divider step ----------------
	logic [SPEED_W:0] dv_r;
	logic             dv_ge;
	always_comb begin
		dv_r  = {drem_q, dvd_q[DVD_W-1]};
		dv_ge = dv_r >= {1'b0, speed_q};
	end

	// ---------------- accumulate and time ----------------
	logic [SUM_W:0]         sum_n;
	logic [CNT_W+LAY_W-1:0] lay_term;
	logic [DVD_W:0]         t_sum;
	logic [43:0]            km_full;
	always_comb begin
		sum_n    = {1'b0, sum_q} + (SUM_W+1)'(leg_q);
		lay_term = (CNT_W+LAY_W)'(cnt_q - 1'b1) * (CNT_W+LAY_W)'(layover_q);
		t_sum    = {1'b0, dvd_q} + (DVD_W+1)'(lay_term);
		km_full  = km_sum[65:22];
	end

	// ---------------- configuration and control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= SPEED_RESET;
			layover_q   <= LAYOVER_RESET;
			prev_lat_q  <= '0;
			prev_lon_q  <= '0;
			have_prev_q <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_SPEED)
					speed_q <= cfg_data[SPEED_W-1:0];
				else if (cfg_index == CFG_LAYOVER)
					layover_q <= cfg_data[LAY_W-1:0];
			end
			if (cmd.accum) begin
				sum_q       <= sum_n[SUM_W] ? '1 : sum_n[SUM_W-1:0];
				if (cnt_q < CNT_W'(MAX_STOPS))
					cnt_q <= cnt_q + 1'b1;
				prev_lat_q  <= cur_lat_q;
				prev_lon_q  <= cur_lon_q;
				have_prev_q <= 1'b1;
			end else if (cmd.time_load) begin
				sum_q       <= '0;
				cnt_q       <= '0;
				have_prev_q <= 1'b0;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			cur_lat_q <= latitude;
			cur_lon_q <= longitude;
			last_q    <= last_stop;
		end
		if (cmd.mul_en)
			prod_q <= prod_d;
		if (cmd.mul_en && cmd.mul == MUL_RAD) begin
			neg_q <= fold_neg;
			sgn_q <= deg_f[DEG_W-1];
		end
		if (cmd.rot_load) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= z0;
		end else if (cmd.rot_step) begin
			if (!z_q[ANG_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end else if (cmd.vec_load) begin
			if (arg_q[MUL_W-1]) begin
				x_q <= root_s;
				y_q <= -ANG_W'(arg_q);
				z_q <= HALF_PI_Q30;
			end else begin
				x_q <= ANG_W'(arg_q);
				y_q <= root_s;
				z_q <= '0;
			end
		end else if (cmd.vec_step) begin
			if (!y_q[ANG_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
		if (cmd.store_sc) begin
			unique case (cmd.slot)
				SLOT_A: begin
					sa_q <= y_q[MUL_W-1:0];
					ca_q <= x_neg[MUL_W-1:0];
				end
				SLOT_B: begin
					sb_q <= y_q[MUL_W-1:0];
					cb_q <= x_neg[MUL_W-1:0];
				end
				default: cd_q <= x_neg[MUL_W-1:0];
			endcase
		end
		if (cmd.p1_save)
			p1_q <= prod_sh[MUL_W-1:0];
		if (cmd.arg_load) begin
			if (arg_sum > ONE_Q30)
				arg_q <= ONE_Q30[MUL_W-1:0];
			else if (arg_sum < -ONE_Q30)
				arg_q <= -ONE_Q30[MUL_W-1:0];
			else
				arg_q <= arg_sum[MUL_W-1:0];
		end
		// 2^60 - c*c, digit pairs from the top
		if (cmd.sqrt_load) begin
			rad_q  <= 64'h1000_0000_0000_0000 - prod_u[63:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= sq_ge ? (sq_r2 - sq_trial) : sq_r2;
			root_q <= {root_q[30:0], sq_ge};
		end
		if (cmd.leg_zero)
			leg_q <= '0;
		else if (cmd.leg_load)
			leg_q <= (km_full > 44'(LEG_MAX)) ? LEG_MAX : km_full[LEG_W-1:0];
		if (cmd.div_load) begin
			dvd_q  <= {sum_q, 8'b0};
			drem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], dv_ge};
			drem_q <= dv_ge ? SPEED_W'(dv_r - {1'b0, speed_q}) : dv_r[SPEED_W-1:0];
		end
		if (cmd.accum) begin
			time_q <= '0;
			err_q  <= 1'b0;
		end else if (cmd.time_load) begin
			if (speed_q == '0) begin
				time_q <= '0;
				err_q  <= 1'b1;
			end else begin
				time_q <= (t_sum > (DVD_W+1)'(32'hFFFF_FFFF)) ? '1 : t_sum[TIME_W-1:0];
				err_q  <= 1'b0;
			end
		end
		if (cmd.out_load) begin
			out_leg_q  <= leg_q;
			out_time_q <= time_q;
			out_done_q <= last_q;
			out_err_q  <= err_q;
		end
	end

	assign st.leg_ok   = have_prev_q && prev_ok && cur_ok;
	assign st.last     = last_q;
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign leg_distance = out_leg_q;
	assign total_time   = out_time_q;
	assign route_done   = out_done_q;
	assign speed_error  = out_err_q;

	a_leg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_leg_q <= LEG_MAX))
		else $error("leg distance above maximum");

	a_time_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_done_q) |-> (out_time_q == '0 && !out_err_q))
		else $error("time or error reported before route end");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=>
		(out_valid_q && $stable(out_leg_q) && $stable(out_time_q)))
		else $error("waiting result changed");

endmodule

/* sv/route_great_circle_travel_time.sv */
`timescale 1ns / 1ps
// Great-circle route travel-time estimator, top level.
//
// One stop item at a time. A first stop, or a leg with an end out of range,
// skips the arithmetic and gives a zero leg; a leg runs through the shared CORDIC
// (three sin/cos rotations and one acos vectoring pass of 24 steps each) and
// the 32-step square root; the closing stop adds the 40-step divider.
// Results wait in an output register, so the next stop is
// taken while a result is still pending. Configuration writes are always ready.
module route_great_circle_travel_time (
	input  logic    clk,
	input  logic    arst_n,
	gctt_stop_if.sink     stop_in,
	gctt_result_if.source result_out,
	gctt_cfg_if.sink      cfg
);
	import gctt_pkg::*;

	cmd_t    cmd;
	status_t st;

	assign cfg.ready = 1'b1;

	gctt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stop_in.valid),
		.in_ready (stop_in.ready),
		.st       (st),
		.cmd      (cmd)
	);

	gctt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.latitude     (stop_in.latitude),
		.longitude    (stop_in.longitude),
		.last_stop    (stop_in.last_stop),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.out_valid    (result_out.valid),
		.out_ready    (result_out.ready),
		.leg_distance (result_out.leg_distance),
		.total_time   (result_out.total_time),
		.route_done   (result_out.route_done),
		.speed_error  (result_out.speed_error)
	);

endmodule

/* test/route_great_circle_travel_time_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the great-circle route travel-time estimator.
module route_great_circle_travel_time_tb;
	import gctt_pkg::*;

	typedef struct packed {
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
		logic                    last;
	} stop_t;

	typedef struct packed {
		logic [LEG_W-1:0]  leg;
		logic [TIME_W-1:0] total;
		logic              done;
		logic              err;
	} trip_t;

	// directed row: stop plus optional typed-in result
	typedef struct packed {
		stop_t stp;
		logic  known;
		trip_t res;
	} row_t;

	localparam longint DEG = 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	gctt_stop_if   stop_ch();
	gctt_result_if res_ch();
	gctt_cfg_if    cfg_ch();

	route_great_circle_travel_time uut (
		.clk(clk), .arst_n(arst_n),
		.stop_in(stop_ch.sink), .result_out(res_ch.source), .cfg(cfg_ch.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// predictor state
	logic [SPEED_W-1:0] cur_speed;
	logic [LAY_W-1:0]   cur_layover;
	longint prv_lat, prv_lon;
	bit     have_prv;
	longint dist_sum;
	int     nstops;

	trip_t  pending_trips[$];
	int     errors = 0;
	int     n_checked = 0;
	int     n_routes = 0;
	bit     hold_off = 0;

	localparam longint ATAN_TBL[32] = '{843314856, 497837829, 263043836, 133525158,
		67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127,
		63, 31, 15, 8, 4, 2, 1, 0};

	function automatic longint to_rad(longint d);
		longint m, r;
		m = d < 0 ? -d : d;
		r = (m * 64'd74961321 + (64'd1 << 17)) >>> 18;
		return d < 0 ? -r : r;
	endfunction

	function automatic void rotate_deg(longint d, output longint s, output longint c);
		longint x, y, z, dx, dy;
		bit flip;
		flip = 0;
		if (d > 90 * DEG) begin
			d = 180 * DEG - d; flip = 1;
		end else if (d < -90 * DEG) begin
			d = -180 * DEG - d; flip = 1;
		end
		z = to_rad(d);
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i; dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TBL[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TBL[i];
			end
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint arc_cos(longint c);
		longint x, y, z, t, dx, dy;
		x = c;
		y = int_sqrt((64'd1 << 60) - c * c);
		z = 0;
		if (x < 0) begin
			t = x; x = y; y = -t; z = 1686629713;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i; dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_TBL[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TBL[i];
			end
		end
		if (z < 0) z = 0;
		if (z > 64'sd3373259426) z = 64'sd3373259426;
		return z;
	endfunction

	function automatic bit on_globe(longint la, longint lo);
		return la <= 90 * DEG && la >= -90 * DEG && lo <= 180 * DEG && lo >= -180 * DEG;
	endfunction

	function automatic longint leg_length(longint la, longint oa, longint lb, longint ob);
		longint sa, ca, sb, cb, sd, cd, d, arg, km;
		if (!on_globe(la, oa) || !on_globe(lb, ob)) return 0;
		rotate_deg(la, sa, ca);
		rotate_deg(lb, sb, cb);
		d = ob - oa;
		if (d > 180 * DEG) d -= 360 * DEG;
		if (d < -180 * DEG) d += 360 * DEG;
		rotate_deg(d, sd, cd);
		arg = ((sa * sb) >>> 30) + ((((ca * cb) >>> 30) * cd) >>> 30);
		if (arg > (64'sd1 << 30)) arg = 64'sd1 << 30;
		if (arg < -(64'sd1 << 30)) arg = -(64'sd1 << 30);
		km = (arc_cos(arg) * 6371 + (64'd1 << 21)) >>> 22;
		if (km > LEG_MAX) km = LEG_MAX;
		return km;
	endfunction

	function automatic trip_t predict_trip(stop_t s);
		trip_t r;
		longint leg, tot;
		leg = 0;
		tot = 0;
		r = '0;
		if (have_prv) begin
			leg = leg_length(prv_lat, prv_lon, longint'(s.lat), longint'(s.lon));
			dist_sum += leg;
			if (dist_sum > 64'hFFFF_FFFF) dist_sum = 64'hFFFF_FFFF;
		end
		if (nstops < MAX_STOPS) nstops++;
		prv_lat = s.lat;
		prv_lon = s.lon;
		have_prv = 1;
		if (s.last) begin
			if (cur_speed == 0) r.err = 1;
			else begin
				tot = (dist_sum << 8) / longint'(cur_speed)
					+ longint'(nstops - 1) * longint'(cur_layover);
				if (tot > 64'hFFFF_FFFF) tot = 64'hFFFF_FFFF;
			end
			have_prv = 0; dist_sum = 0; nstops = 0;
		end
		r.leg = leg[LEG_W-1:0];
		r.total = tot[TIME_W-1:0];
		r.done = s.last;
		return r;
	endfunction

	// result side: random stall pattern, long hold-off on request
	always @(negedge clk) begin
		if (!arst_n || hold_off) res_ch.ready <= 1'b0;
		else res_ch.ready <= ($time / 4000) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		trip_t exp_t;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_trips.size() == 0) begin
				$display("%0t: unexpected result leg=%0d", $time, res_ch.leg_distance);
				errors++;
			end else begin
				exp_t = pending_trips.pop_front();
				n_checked++;
				if (res_ch.leg_distance !== exp_t.leg || res_ch.total_time !== exp_t.total
						|| res_ch.route_done !== exp_t.done
						|| res_ch.speed_error !== exp_t.err) begin
					$display("%0t: mismatch expected leg=%0d time=%0d done=%0b err=%0b", $time,
						exp_t.leg, exp_t.total, exp_t.done, exp_t.err);
					$display("%0t:          actual   leg=%0d time=%0d done=%0b err=%0b", $time,
						res_ch.leg_distance, res_ch.total_time, res_ch.route_done,
						res_ch.speed_error);
					errors++;
				end
			end
		end
	end

	int burst_left = 0;

	task automatic send_stop(stop_t s, bit known, trip_t res);
		trip_t p;
		int    gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				stop_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		stop_ch.valid <= 1'b1;
		stop_ch.latitude <= s.lat;
		stop_ch.longitude <= s.lon;
		stop_ch.last_stop <= s.last;
		do @(posedge clk); while (!stop_ch.ready);
		p = predict_trip(s);
		if (known && p !== res) begin
			$display("%0t: table row expected %h, predictor %h", $time, res, p);
			errors++;
		end
		pending_trips.push_back(p);
		if (s.last) n_routes++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		stop_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_trips.size() != 0 && guard < 200000) begin
			@(negedge clk); guard++;
		end
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == CFG_SPEED) cur_speed = val;
		else cur_layover = val[LAY_W-1:0];
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic stop_t rand_stop(bit wild, bit last);
		stop_t s;
		if (wild) begin
			s.lat = LAT_W'($urandom); s.lon = LON_W'($urandom);
		end else begin
			s.lat = LAT_W'($urandom_range(0, 180 * 65536) - 90 * 65536);
			s.lon = LON_W'($urandom_range(0, 360 * 65536) - 180 * 65536);
		end
		s.last = last;
		return s;
	endfunction

	function automatic row_t mk(longint la, longint lo, bit last, bit known = 0,
			longint leg = 0, longint tot = 0, bit err = 0);
		row_t r;
		r.stp.lat = LAT_W'(la); r.stp.lon = LON_W'(lo); r.stp.last = last;
		r.known = known;
		r.res.leg = LEG_W'(leg); r.res.total = TIME_W'(tot); r.res.done = last;
		r.res.err = err;
		return r;
	endfunction

	row_t plan[$];

	initial begin
		stop_t s;
		int len;
		stop_ch.valid = 0; stop_ch.latitude = 0; stop_ch.longitude = 0; stop_ch.last_stop = 0;
		cfg_ch.valid = 0; cfg_ch.index = CFG_SPEED; cfg_ch.data = 0;
		res_ch.ready = 0;
		cur_speed = SPEED_RESET; cur_layover = LAYOVER_RESET;
		have_prv = 0; dist_sum = 0; nstops = 0; prv_lat = 0; prv_lon = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single stop, same point twice, poles, antimeridian, out-of-range and field extremes
		plan.push_back(mk(0, 0, 1, 1, 0, 0));
		plan.push_back(mk(10 * DEG, 20 * DEG, 0, 1, 0, 0));
		plan.push_back(mk(10 * DEG, 20 * DEG, 1));
		plan.push_back(mk(90 * DEG, 0, 0, 1, 0, 0));
		plan.push_back(mk(-90 * DEG, 0, 0));
		plan.push_back(mk(0, 180 * DEG, 0));
		plan.push_back(mk(0, -180 * DEG, 0));
		plan.push_back(mk(45 * DEG, 179 * DEG, 0));
		plan.push_back(mk(-45 * DEG, -179 * DEG, 1));
		plan.push_back(mk(90 * DEG + 1, 0, 0, 1, 0, 0));
		plan.push_back(mk(0, 0, 0, 1, 0, 0));
		plan.push_back(mk(0, 180 * DEG + 1, 0, 1, 0, 0));
		plan.push_back(mk(-8388608, -16777216, 0, 1, 0, 0));
		plan.push_back(mk(8388607, 16777215, 1, 1, 0, 4 * 256));
		plan.push_back(mk(0, 0, 0));
		plan.push_back(mk(0, 90 * DEG, 0));
		plan.push_back(mk(0, -90 * DEG, 1));
		foreach (plan[i]) send_stop(plan[i].stp, plan[i].known, plan[i].res);
		drain();

		// configuration extremes, zero speed and saturation
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_SPEED, 0); write_reg(CFG_LAYOVER, 0); end
				1: begin write_reg(CFG_SPEED, 1); write_reg(CFG_LAYOVER, 24'h00FFFF); end
				2: begin write_reg(CFG_SPEED, 24'hFFFFFF); write_reg(CFG_LAYOVER, 1); end
				3: begin
					write_reg(CFG_SPEED, CFG_DATA_W'($urandom));
					write_reg(CFG_LAYOVER, CFG_DATA_W'($urandom));
				end
				4: begin
					write_reg(CFG_SPEED, CFG_DATA_W'($urandom_range(1, 2000)));
					write_reg(CFG_LAYOVER, 24'h00FFFF);
				end
				default: begin
					write_reg(CFG_SPEED, SPEED_RESET);
					write_reg(CFG_LAYOVER, CFG_DATA_W'(LAYOVER_RESET));
				end
			endcase
			for (int k = 0; k < 300; ) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 270)
					: $urandom_range(1, 8);
				for (int j = 0; j < len; j++) begin
					s = rand_stop($urandom_range(0, 9) == 0, j == len - 1);
					send_stop(s, 0, '0);
					k++;
					if (ph == 3 && k == 40) begin
						// hold the result side while stops keep coming
						fork
							begin
								hold_off = 1;
								repeat (2000) @(negedge clk);
								hold_off = 0;
							end
						join_none
					end
				end
			end
			drain();
		end

		$display("Checked %0d results over %0d routes, six register settings.",
			n_checked, n_routes);
		if (errors == 0 && pending_trips.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/gctt_pkg.sv
sv/gctt_if.sv
sv/gctt_ctrl.sv
sv/gctt_dp.sv
sv/route_great_circle_travel_time.sv
test/route_great_circle_travel_time_tb.sv
